// ===== rtl/mb_pkg.sv =====
package mb_pkg;

    // grid and number format
    localparam int GRID_COLUMNS  = 1024;
    localparam int GRID_ROWS     = 1024;
    localparam int FRACTION_BITS = 28;

    localparam int IDX_W   = 10;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 16;
    localparam int PROD_W  = 2 * WORD_W;
    localparam int CFG_IDX_W = 3;

    // squared terms after the fraction shift
    localparam int XS_W = PROD_W - FRACTION_BITS;
    // cross term after the shift by one less
    localparam int XY_W = PROD_W - FRACTION_BITS + 1;
    // sums ahead of saturation: z update and c = origin + index*step
    localparam int ZSUM_W = ((XY_W > WORD_W) ? XY_W : WORD_W) + 2;
    localparam int CSUM_W = WORD_W + IDX_W + 2;
    localparam int SAT_W  = (ZSUM_W > CSUM_W) ? ZSUM_W : CSUM_W;

    // escape bound 2*2 in fixed point
    localparam logic [PROD_W:0] ESC_BOUND = (PROD_W + 1)'(4) << FRACTION_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd4;

    typedef struct packed {
        logic signed [WORD_W-1:0]  origin_real;
        logic signed [WORD_W-1:0]  origin_imag;
        logic signed [WORD_W-1:0]  step_real;
        logic signed [WORD_W-1:0]  step_imag;
        logic        [COUNT_W-1:0] iteration_limit;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_C_DONE,
        ST_XX,
        ST_YY,
        ST_XY,
        ST_UPD,
        ST_DONE
    } t_state;

    // clip to the signed word range
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(32'sh7FFFFFFF);
        lo = SAT_W'($signed(32'h80000000));
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return $signed(32'h80000000);
        end else begin
            return $signed(v[WORD_W-1:0]);
        end
    endfunction

endpackage

// ===== rtl/mb_cfg_regs.sv =====
module mb_cfg_regs
    import mb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_real     <= $signed(32'hE0000000);
            r_cfg.origin_imag     <= $signed(32'hF0000000);
            r_cfg.step_real       <= 32'sd786432;
            r_cfg.step_imag       <= 32'sd524288;
            r_cfg.iteration_limit <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_REAL: r_cfg.origin_real     <= $signed(i_cfg_data);
                CFG_ORIGIN_IMAG: r_cfg.origin_imag     <= $signed(i_cfg_data);
                CFG_STEP_REAL:   r_cfg.step_real       <= $signed(i_cfg_data);
                CFG_STEP_IMAG:   r_cfg.step_imag       <= $signed(i_cfg_data);
                CFG_ITER_LIMIT:  r_cfg.iteration_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/mb_mul.sv =====
module mb_mul
    import mb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [WORD_W-1:0] i_a,
    input  logic signed [WORD_W-1:0] i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // one signed 32x32 product per cycle while i_en is high, registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/mb_core.sv =====
module mb_core
    import mb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [IDX_W-1:0]   i_column,
    input  logic [IDX_W-1:0]   i_row,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [COUNT_W-1:0] o_count
);

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]          r_col;
    logic [IDX_W-1:0]          r_row;
    logic signed [WORD_W-1:0]  r_cr;
    logic signed [WORD_W-1:0]  r_ci;
    logic signed [WORD_W-1:0]  r_x;
    logic signed [WORD_W-1:0]  r_y;
    logic [XS_W-1:0]           r_xs;
    logic [XS_W-1:0]           r_ys;
    logic [COUNT_W-1:0]        r_n;
    logic                      r_out_valid;
    logic [COUNT_W-1:0]        r_out_count;

    logic                      mul_en;
    logic signed [WORD_W-1:0]  mul_a;
    logic signed [WORD_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [IDX_W-1:0]          col_clip;
    logic [IDX_W-1:0]          row_clip;
    logic                      accept;
    logic                      escaped;
    logic [COUNT_W-1:0]        n_inc;
    logic                      at_limit;
    logic                      out_free;
    logic signed [SAT_W-1:0]   xs_s;
    logic signed [SAT_W-1:0]   ys_s;
    logic signed [SAT_W-1:0]   xy_s;
    logic signed [SAT_W-1:0]   c_sum;
    logic signed [WORD_W-1:0]  c_origin;

    mb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // clamp indexes to the grid
    always_comb begin
        col_clip = i_column;
        row_clip = i_row;
        if (17'(i_column) >= 17'(GRID_COLUMNS)) begin
            col_clip = IDX_W'(GRID_COLUMNS - 1);
        end
        if (17'(i_row) >= 17'(GRID_ROWS)) begin
            row_clip = IDX_W'(GRID_ROWS - 1);
        end
    end

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    // iteration terms
    assign escaped  = ((PROD_W + 1)'(r_xs) + (PROD_W + 1)'(r_ys)) > ESC_BOUND;
    assign n_inc    = r_n + COUNT_W'(1);
    assign at_limit = n_inc >= i_cfg.iteration_limit;
    assign xs_s     = SAT_W'($signed({1'b0, r_xs}));
    assign ys_s     = SAT_W'($signed({1'b0, r_ys}));
    assign xy_s     = SAT_W'($signed(prod[PROD_W-1:FRACTION_BITS-1]));
    assign c_origin = (r_state == ST_C_IM) ? i_cfg.origin_real : i_cfg.origin_imag;
    assign c_sum    = SAT_W'(c_origin) + SAT_W'(prod);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_s_tvalid) n_state = ST_C_RE;
            ST_C_RE:   n_state = ST_C_IM;
            ST_C_IM:   n_state = ST_C_DONE;
            ST_C_DONE: n_state = (i_cfg.iteration_limit == '0) ? ST_DONE : ST_XX;
            ST_XX:     n_state = ST_YY;
            ST_YY:     n_state = ST_XY;
            ST_XY:     n_state = ST_UPD;
            ST_UPD:    n_state = (escaped || at_limit) ? ST_DONE : ST_XX;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // multiplier operand select and handshake
    always_comb begin
        mul_en     = 1'b0;
        mul_a      = r_x;
        mul_b      = r_x;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_tready = i_rst_n;
            ST_C_RE: begin
                mul_en = 1'b1;
                mul_a  = WORD_W'($signed({1'b0, r_col}));
                mul_b  = i_cfg.step_real;
            end
            ST_C_IM: begin
                mul_en = 1'b1;
                mul_a  = WORD_W'($signed({1'b0, r_row}));
                mul_b  = i_cfg.step_imag;
            end
            ST_XX: mul_en = 1'b1;
            ST_YY: begin
                mul_en = 1'b1;
                mul_a  = r_y;
                mul_b  = r_y;
            end
            ST_XY: begin
                mul_en = 1'b1;
                mul_b  = r_y;
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_col <= col_clip;
                    r_row <= row_clip;
                    r_x   <= '0;
                    r_y   <= '0;
                    r_n   <= '0;
                end
            end
            ST_C_IM:   r_cr <= sat32(c_sum);
            ST_C_DONE: r_ci <= sat32(c_sum);
            ST_YY:     r_xs <= prod[PROD_W-1:FRACTION_BITS];
            ST_XY:     r_ys <= prod[PROD_W-1:FRACTION_BITS];
            ST_UPD: begin
                if (!escaped) begin
                    r_x <= sat32(xs_s - ys_s + SAT_W'(r_cr));
                    r_y <= sat32(xy_s + SAT_W'(r_ci));
                    r_n <= n_inc;
                end
            end
            default: ;
        endcase
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_count <= r_n;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_count    = r_out_count;

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
// channel   direction  signals                          word contents
// s         in         i_s_tvalid/o_s_tready/i_s_tdata  column, row
// m         out        o_m_tvalid/i_m_tready/o_m_tdata  iteration_count
// cfg       in         i_cfg_we/i_cfg_index/i_cfg_data  register write
//
// a single 32x32 multiplier is shared by c setup and the three products
// of each iteration, four steps per pass; the result word is registered
// as the core leaves its done state and tready returns with it, so the
// pixels are computed one at a time, through c setup and the passes.
// synchronous active-low reset loads the default view and limit.
// the next pixel is taken while a finished word waits on the m side; a
// pixel that finishes before that word leaves holds in its last step.
module mandelbrot_escape_time
    import mb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,   // [9:0] column, [19:10] row
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [15:0]          o_m_tdata,   // [15:0] iteration_count
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_cfg cfg;

    mb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mb_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_column   (i_s_tdata[IDX_W-1:0]),
        .i_row      (i_s_tdata[2*IDX_W-1:IDX_W]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_count    (o_m_tdata)
    );

endmodule

// ===== test/tb_mandelbrot_escape_time.sv =====
module tb_mandelbrot_escape_time;
    import mb_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_LIMIT    = 1_000_000;
    localparam int HOLD_CYCLES   = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 8;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

    // |z|^2 bound of 2*2 and a few Q4.28 constants
    localparam longint RADIUS_SQ   = longint'(4) <<< FRACTION_BITS;
    localparam int     Q_ONE       = 1 << FRACTION_BITS;
    localparam int     Q_QUARTER   = Q_ONE / 4;
    localparam int     Q_MINUS_TWO = -2 * Q_ONE;

    typedef enum int {RX_STEADY, RX_CHOPPY, RX_SLUGGISH} t_rx_mode;

    typedef struct {
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   row;
        logic [COUNT_W-1:0] count;
    } t_pixel_count;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata;   // [9:0] column, [19:10] row
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [15:0]          o_m_tdata;   // [15:0] iteration_count
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    t_cfg         view;
    t_pixel_count expected_counts[$];
    t_pixel_count got;
    int           errors = 0;
    int           burst_left = 0;
    int           hold_requests = 0;

    mandelbrot_escape_time dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // clip to the signed 32-bit range
    function automatic longint clip_word(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) begin
            return longint'(32'sh7FFF_FFFF);
        end else if (v < -longint'(64'sh8000_0000)) begin
            return -longint'(64'sh8000_0000);
        end
        return v;
    endfunction

    // escape time of one pixel under the given view
    function automatic logic [COUNT_W-1:0] predict_iterations(input t_cfg v,
                                                              input logic [IDX_W-1:0] col,
                                                              input logic [IDX_W-1:0] row);
        longint      cr;
        longint      ci;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        longint      xy;
        int unsigned c_idx;
        int unsigned r_idx;
        int unsigned n;
        c_idx = (col >= GRID_COLUMNS) ? GRID_COLUMNS - 1 : col;
        r_idx = (row >= GRID_ROWS) ? GRID_ROWS - 1 : row;
        cr = clip_word(longint'($signed(v.origin_real))
                       + longint'(c_idx) * longint'($signed(v.step_real)));
        ci = clip_word(longint'($signed(v.origin_imag))
                       + longint'(r_idx) * longint'($signed(v.step_imag)));
        x = 0;
        y = 0;
        n = 0;
        while (n < v.iteration_limit) begin
            xs = (x * x) >>> FRACTION_BITS;
            ys = (y * y) >>> FRACTION_BITS;
            if (xs + ys > RADIUS_SQ) begin
                break;
            end
            xy = (x * y) >>> (FRACTION_BITS - 1);
            x = clip_word(xs - ys + cr);
            y = clip_word(xy + ci);
            n++;
        end
        return n[COUNT_W-1:0];
    endfunction

    // result side: stall pattern of its own plus requested long hold-offs
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       holds_seen;
        mode = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        holds_seen = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(RX_STEADY, RX_SLUGGISH));
                    mode_left = $urandom_range(1, 200);
                end
                mode_left--;
                case (mode)
                    RX_STEADY: begin
                        i_m_tready = 1'b1;
                    end
                    RX_CHOPPY: begin
                        i_m_tready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_m_tready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // compare each result word with the oldest expected count
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (expected_counts.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %0d",
                         $time, o_m_tdata);
            end else begin
                got = expected_counts.pop_front();
                if (o_m_tdata !== got.count) begin
                    errors++;
                    $display("%0t: count mismatch at column %0d row %0d:",
                             $time, got.col, got.row,
                             " expected %0d, got %0d", got.count, o_m_tdata);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[mandelbrot_escape_time] ERROR");
        $finish;
    end

    // register write, mirrored into the predicted view
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_ORIGIN_REAL: view.origin_real = data;
            CFG_ORIGIN_IMAG: view.origin_imag = data;
            CFG_STEP_REAL:   view.step_real = data;
            CFG_STEP_IMAG:   view.step_imag = data;
            CFG_ITER_LIMIT:  view.iteration_limit = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // offer one pixel word, in bursts with random gaps between them
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        int gap;
        t_pixel_count want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                i_s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata = {4'b0, row, col};
        do @(posedge i_clk); while (!o_s_tready);
        want.col = col;
        want.row = row;
        want.count = predict_iterations(view, col, row);
        expected_counts.push_back(want);
    endtask

    // stop offering and let every outstanding count come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // default view straight out of reset
    task automatic test_reset_view();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
    endtask

    // register corners and the special cases of the escape loop
    task automatic test_register_edges();
        wait_idle();
        // writes to unused indexes leave the view alone
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_MID, '0);
        cfg_write(CFG_SPARE_HI, 32'h5555_5555);
        send_pixel(10'd512, 10'd512);

        // zero limit and a limit of one
        wait_idle();
        cfg_write(CFG_ITER_LIMIT, 0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        wait_idle();
        cfg_write(CFG_ITER_LIMIT, 1);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);

        // c saturates high on the real axis and low on the imaginary one
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, 32'h7FFF_FFFF);
        cfg_write(CFG_ORIGIN_IMAG, 32'h8000_0000);
        cfg_write(CFG_STEP_REAL, 32'h7FFF_FFFF);
        cfg_write(CFG_STEP_IMAG, 32'h8000_0000);
        cfg_write(CFG_ITER_LIMIT, 16);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1, 10'd1);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);

        // tiny negative steps around zero
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, 0);
        cfg_write(CFG_ORIGIN_IMAG, 0);
        cfg_write(CFG_STEP_REAL, '1);
        cfg_write(CFG_STEP_IMAG, '1);
        send_pixel(10'd1023, 10'd1023);

        // c = -2 keeps |z|^2 exactly at the bound
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, Q_MINUS_TWO);
        cfg_write(CFG_STEP_REAL, 0);
        cfg_write(CFG_STEP_IMAG, 0);
        cfg_write(CFG_ITER_LIMIT, 300);
        send_pixel(10'd7, 10'd3);

        // c = 1/4, the cusp of the main cardioid
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, Q_QUARTER);
        send_pixel(10'd0, 10'd0);

        // largest limit on a point that never escapes
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, 0);
        cfg_write(CFG_ITER_LIMIT, 32'h0000_FFFF);
        send_pixel(10'd1023, 10'd0);
    endtask

    // result side held off while pixels keep coming
    task automatic test_backpressure();
        wait_idle();
        cfg_write(CFG_ORIGIN_REAL, Q_MINUS_TWO);
        cfg_write(CFG_ORIGIN_IMAG, -Q_ONE);
        cfg_write(CFG_STEP_REAL, 786432);
        cfg_write(CFG_STEP_IMAG, 524288);
        cfg_write(CFG_ITER_LIMIT, 6);
        hold_requests++;
        repeat (10) begin
            send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end
    endtask

    // random views over the set, with a few phases of raw register noise
    task automatic test_random_views();
        logic [COUNT_W-1:0] lim;
        int                 span;
        repeat (RANDOM_PHASES) begin
            wait_idle();
            lim = (burst_left % 4 == 0 && $urandom_range(0, 3) == 0)
                  ? COUNT_W'(128) : COUNT_W'($urandom_range(1, 48));
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_ORIGIN_REAL, $urandom());
                cfg_write(CFG_ORIGIN_IMAG, $urandom());
                cfg_write(CFG_STEP_REAL, $urandom());
                cfg_write(CFG_STEP_IMAG, $urandom());
            end else begin
                // walk right from about -2.5 or left from about 1.0
                span = $urandom_range(0, Q_ONE);
                if ($urandom_range(0, 1)) begin
                    cfg_write(CFG_ORIGIN_REAL, -(5 * Q_ONE / 2) + span);
                    cfg_write(CFG_STEP_REAL, $urandom_range(1, 1 << 20));
                end else begin
                    cfg_write(CFG_ORIGIN_REAL, Q_ONE - span);
                    cfg_write(CFG_STEP_REAL, -int'($urandom_range(1, 1 << 20)));
                end
                span = $urandom_range(0, Q_ONE);
                if ($urandom_range(0, 1)) begin
                    cfg_write(CFG_ORIGIN_IMAG, -(3 * Q_ONE / 2) + span);
                    cfg_write(CFG_STEP_IMAG, $urandom_range(1, 1 << 19));
                end else begin
                    cfg_write(CFG_ORIGIN_IMAG, (3 * Q_ONE / 2) - span);
                    cfg_write(CFG_STEP_IMAG, -int'($urandom_range(1, 1 << 19)));
                end
            end
            cfg_write(CFG_ITER_LIMIT, WORD_W'(lim));
            repeat (PHASE_ITEMS) begin
                send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        view.origin_real = 32'hE000_0000;
        view.origin_imag = 32'hF000_0000;
        view.step_real = 32'd786432;
        view.step_imag = 32'd524288;
        view.iteration_limit = 16'd256;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_view();
        test_register_edges();
        test_backpressure();
        test_random_views();
        wait_idle();

        if (errors == 0) begin
            $display("[mandelbrot_escape_time] OK");
        end else begin
            $display("[mandelbrot_escape_time] ERROR");
        end
        $finish;
    end

endmodule

// ===== mandelbrot_escape_time.f =====
rtl/mb_pkg.sv
rtl/mb_cfg_regs.sv
rtl/mb_mul.sv
rtl/mb_core.sv
rtl/mandelbrot_escape_time.sv
test/tb_mandelbrot_escape_time.sv
